/* sv/nmea_sentence_validator_core_macros.svh */
// Assertion macros shared by the sentence validator modules.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef NMEA_SENTENCE_VALIDATOR_CORE_MACROS_SVH
`define NMEA_SENTENCE_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define NSV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define NSV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/nsv_pkg.sv */
// Types and constants of the NMEA sentence validator.
// No dependencies; used by the interfaces, the tracker and the top level.
`timescale 1ns / 1ps

package nsv_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [23:0] TAG_GGA = "GGA";
    localparam logic [23:0] TAG_GLL = "GLL";
    localparam logic [23:0] TAG_GSA = "GSA";
    localparam logic [23:0] TAG_GSV = "GSV";
    localparam logic [23:0] TAG_RMC = "RMC";
    localparam logic [23:0] TAG_VTG = "VTG";

    localparam int unsigned FIELD_W = 5;
    localparam logic [FIELD_W-1:0] FIELD_SAT = 5'd31;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FRAMING  = 3'd1,
        ST_DIGITS   = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_FIELDS   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        KIND_RAW = 3'd0,
        KIND_GGA = 3'd1,
        KIND_GLL = 3'd2,
        KIND_GSA = 3'd3,
        KIND_GSV = 3'd4,
        KIND_RMC = 3'd5,
        KIND_VTG = 3'd6
    } kind_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_number;
        logic               is_separator;
        logic               sentence_done;
        status_t            status;
        kind_t              sentence_kind;
        logic [7:0]         computed_checksum;
    } result_t;

    // Bit 4 set when the byte is not a hex digit; low nibble is the value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic kind_t kind_of(input logic [23:0] tag);
        kind_t k;
        case (tag)
            TAG_GGA: k = KIND_GGA;
            TAG_GLL: k = KIND_GLL;
            TAG_GSA: k = KIND_GSA;
            TAG_GSV: k = KIND_GSV;
            TAG_RMC: k = KIND_RMC;
            TAG_VTG: k = KIND_VTG;
            default: k = KIND_RAW;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] min_commas(input kind_t k);
        logic [4:0] m;
        case (k)
            KIND_GGA: m = 5'd13;
            KIND_GLL: m = 5'd6;
            KIND_GSA: m = 5'd16;
            KIND_GSV: m = 5'd18;
            KIND_RMC: m = 5'd10;
            KIND_VTG: m = 5'd7;
            default:  m = 5'd0;
        endcase
        return m;
    endfunction

endpackage

/* sv/nsv_channels.sv */
// Valid/ready channel interfaces of the NMEA sentence validator.
// Depends on nsv_pkg for the field number width.
`timescale 1ns / 1ps

interface nsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface nsv_out_if;
    logic                         valid;
    logic                         ready;
    logic [nsv_pkg::FIELD_W-1:0]  field_number;
    logic                         is_separator;
    logic                         sentence_done;
    logic [2:0]                   status;
    logic [2:0]                   sentence_kind;
    logic [7:0]                   computed_checksum;

    modport source (
        output valid, output field_number, output is_separator, output sentence_done,
        output status, output sentence_kind, output computed_checksum, input ready
    );
    modport sink (
        input valid, input field_number, input is_separator, input sentence_done,
        input status, input sentence_kind, input computed_checksum, output ready
    );
endinterface

/* sv/nsv_tracker.sv */
// Per-sentence state and single-pass result logic of the sentence validator.
// Depends on nsv_pkg and nmea_sentence_validator_core_macros.svh.
`timescale 1ns / 1ps
`include "nmea_sentence_validator_core_macros.svh"

module nsv_tracker #(
    parameter int unsigned FIELD_COUNT_MAX = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             final_byte,
    output nsv_pkg::result_t result
);

    localparam int unsigned CW = $clog2(FIELD_COUNT_MAX + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(FIELD_COUNT_MAX);
    localparam logic [CW-1:0] COUNT_SAT = CW'(nsv_pkg::FIELD_SAT);

    logic [2:0]      pos_reg, pos_next;
    logic            head_ok_reg, head_ok_next;
    logic [7:0]      xor_reg, xor_next;
    logic [7:0]      tail_reg [5];
    logic [7:0]      tail_next [5];
    logic [23:0]     prefix_reg, prefix_next;
    nsv_pkg::kind_t  kind_reg, kind_next;
    logic [CW-1:0]   count_reg, count_next;

    logic            sep;
    logic [7:0]      chk;
    logic [4:0]      hi;
    logic [4:0]      lo;
    logic            framing_bad;
    nsv_pkg::status_t status;

    always_comb
    begin
        sep = (pos_reg == 3'd7) && (data_byte == nsv_pkg::CH_COMMA);

        head_ok_next = head_ok_reg;
        if (pos_reg == 3'd0 && data_byte != nsv_pkg::CH_DOLLAR) begin
            head_ok_next = 1'b0;
        end
        if (pos_reg == 3'd1 && data_byte != nsv_pkg::CH_G) begin
            head_ok_next = 1'b0;
        end

        xor_next = (pos_reg != 3'd0) ? (xor_reg ^ data_byte) : xor_reg;

        prefix_next = (pos_reg >= 3'd3 && pos_reg <= 3'd5) ?
                      {prefix_reg[15:0], data_byte} : prefix_reg;

        kind_next = kind_reg;
        if (pos_reg == 3'd6) begin
            kind_next = (data_byte == nsv_pkg::CH_COMMA) ?
                        nsv_pkg::kind_of(prefix_reg) : nsv_pkg::KIND_RAW;
        end

        count_next = (sep && count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        for (int i = 0; i < 4; i++) begin
            tail_next[i] = tail_reg[i + 1];
        end
        tail_next[4] = data_byte;

        pos_next = (pos_reg == 3'd7) ? pos_reg : pos_reg + 3'd1;

        chk = xor_next ^ tail_next[0] ^ tail_next[1] ^ tail_next[2]
              ^ tail_next[3] ^ tail_next[4];
        hi = nsv_pkg::hex_digit(tail_next[1]);
        lo = nsv_pkg::hex_digit(tail_next[2]);

        framing_bad = !head_ok_next || (pos_reg < 3'd6)
                      || (tail_next[0] != nsv_pkg::CH_STAR)
                      || (tail_next[3] != nsv_pkg::CH_CR)
                      || (tail_next[4] != nsv_pkg::CH_LF);

        if (framing_bad) begin
            status = nsv_pkg::ST_FRAMING;
        end else if (hi[4] || lo[4]) begin
            status = nsv_pkg::ST_DIGITS;
        end else if ({hi[3:0], lo[3:0]} != chk) begin
            status = nsv_pkg::ST_MISMATCH;
        end else if (kind_next != nsv_pkg::KIND_RAW
                     && count_next < CW'(nsv_pkg::min_commas(kind_next))) begin
            status = nsv_pkg::ST_FIELDS;
        end else begin
            status = nsv_pkg::ST_OK;
        end

        result.field_number  = (count_reg > COUNT_SAT) ? nsv_pkg::FIELD_SAT
                                                       : count_reg[nsv_pkg::FIELD_W-1:0];
        result.is_separator  = sep;
        result.sentence_done = final_byte;
        if (final_byte) begin
            result.status            = status;
            result.sentence_kind     = kind_next;
            result.computed_checksum = chk;
        end else begin
            result.status            = nsv_pkg::ST_OK;
            result.sentence_kind     = nsv_pkg::KIND_RAW;
            result.computed_checksum = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg     <= 3'd0;
            head_ok_reg <= 1'b1;
            xor_reg     <= 8'h00;
            prefix_reg  <= 24'h000000;
            kind_reg    <= nsv_pkg::KIND_RAW;
            count_reg   <= '0;
            for (int i = 0; i < 5; i++) begin
                tail_reg[i] <= 8'h00;
            end
        end else if (accept) begin
            if (final_byte) begin
                pos_reg     <= 3'd0;
                head_ok_reg <= 1'b1;
                xor_reg     <= 8'h00;
                prefix_reg  <= 24'h000000;
                kind_reg    <= nsv_pkg::KIND_RAW;
                count_reg   <= '0;
                for (int i = 0; i < 5; i++) begin
                    tail_reg[i] <= 8'h00;
                end
            end else begin
                pos_reg     <= pos_next;
                head_ok_reg <= head_ok_next;
                xor_reg     <= xor_next;
                prefix_reg  <= prefix_next;
                kind_reg    <= kind_next;
                count_reg   <= count_next;
                for (int i = 0; i < 5; i++) begin
                    tail_reg[i] <= tail_next[i];
                end
            end
        end
    end

    `NSV_ASSERT_NEXT(a_final_clears, accept && final_byte, pos_reg == 3'd0 && count_reg == '0)
    `NSV_ASSERT_NEXT(a_pos_advance, accept && !final_byte && pos_reg != 3'd7, pos_reg == $past(pos_reg) + 3'd1)
    `NSV_ASSERT_SAME(a_kind_late, pos_reg < 3'd7, kind_reg == nsv_pkg::KIND_RAW && count_reg == '0)

endmodule

/* sv/nmea_sentence_validator_core.sv */
// NMEA 0183 sentence validator: takes one sentence byte per cycle, unless the skid
// entry is full, and returns one registered result per byte. The per-sentence state
// (position, running XOR, last five bytes, type tag, comma count) is updated in a
// single pass, so a new byte is accepted every cycle while the skid entry is empty; an
// output register plus one skid entry hold one more byte when the results stall.
// Depends on nsv_pkg, nsv_channels and nsv_tracker.
`timescale 1ns / 1ps
`include "nmea_sentence_validator_core_macros.svh"

module nmea_sentence_validator_core #(
    parameter int unsigned FIELD_COUNT_MAX = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    nsv_in_if.sink     sentence,
    nsv_out_if.source  result
);

    logic             accept;
    logic             pop;
    nsv_pkg::result_t step_result;
    nsv_pkg::result_t out_reg;
    nsv_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    assign sentence.ready = !skid_valid_reg;
    assign accept = sentence.valid && sentence.ready;
    assign pop    = out_valid_reg && result.ready;

    nsv_tracker #(
        .FIELD_COUNT_MAX (FIELD_COUNT_MAX)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (sentence.data_byte),
        .final_byte (sentence.final_byte),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= step_result;
            end else begin
                out_reg <= step_result;
            end
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.field_number      = out_reg.field_number;
    assign result.is_separator      = out_reg.is_separator;
    assign result.sentence_done     = out_reg.sentence_done;
    assign result.status            = out_reg.status;
    assign result.sentence_kind     = out_reg.sentence_kind;
    assign result.computed_checksum = out_reg.computed_checksum;

    `NSV_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `NSV_ASSERT_SAME(a_skid_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !result.ready))
    `NSV_ASSERT_SAME(a_idle_fields, out_valid_reg && !out_reg.sentence_done, out_reg.status == nsv_pkg::ST_OK && out_reg.sentence_kind == nsv_pkg::KIND_RAW)

endmodule
